/* rtl/core/nrcts_pkg.sv */
// Shared types, constants and helper functions for the RMC sentence checker.
// No dependencies; every other file of the block depends on this package.
package nrcts_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W = 4;
    localparam int CHK_W = 12;
    localparam int TIME_CHARS = 6;

    localparam logic [POS_W-1:0] POS_MAX = 4'd15;
    localparam logic [POS_W-1:0] POS_PREFIX_END = 4'd6;
    localparam logic [POS_W-1:0] POS_TIME_FIRST = 4'd7;
    localparam logic [POS_W-1:0] POS_TIME_LAST = 4'd12;
    localparam logic [POS_W-1:0] POS_COMMA = 4'd8;

    localparam logic [BYTE_W-1:0] CHAR_STAR = 8'h2A;
    localparam logic [BYTE_W-1:0] CHAR_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CHAR_ZERO = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE = 8'h39;
    localparam logic [BYTE_W-1:0] HEX_SPLIT = 8'd58;
    localparam logic [CHK_W-1:0] HEX_OFF_DIGIT = 12'd48;
    localparam logic [CHK_W-1:0] HEX_OFF_LETTER = 12'd55;

    // Local time is UTC plus this many hours.
    localparam logic [6:0] ZONE_HOURS = 7'd8;

    typedef enum logic [1:0] {
        PH_BEFORE_STAR,
        PH_FIRST_HEX,
        PH_SECOND_HEX,
        PH_DONE
    } t_phase;

    typedef logic [TIME_CHARS-1:0][BYTE_W-1:0] t_clock_chars;

    typedef struct packed {
        logic         ok;
        t_clock_chars clock_chars;
    } t_result;

    // Expected character of the "$GPRMC" talker and sentence prefix.
    function automatic logic [BYTE_W-1:0] prefix_char(input logic [2:0] idx);
        logic [BYTE_W-1:0] c;
        case (idx)
            3'd0: c = 8'h24;
            3'd1: c = 8'h47;
            3'd2: c = 8'h50;
            3'd3: c = 8'h52;
            3'd4: c = 8'h4D;
            3'd5: c = 8'h43;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    // Uppercase-only hex mapping, wrapping modulo 4096 for non-hex bytes.
    function automatic logic [CHK_W-1:0] hex_value(input logic [BYTE_W-1:0] c);
        logic [CHK_W-1:0] off;
        off = (c < HEX_SPLIT) ? HEX_OFF_DIGIT : HEX_OFF_LETTER;
        return {4'b0, c} - off;
    endfunction

    function automatic logic is_digit(input logic [BYTE_W-1:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

endpackage

/* rtl/core/nrcts_if.sv */
// Valid/ready channel interfaces for the sentence byte input and result output.
// Depends on nrcts_pkg for the byte width of its fields.
interface nrcts_in_if;
    logic                         valid;
    logic                         ready;
    logic [nrcts_pkg::BYTE_W-1:0] sentence_byte;
    logic                         last_byte;

    modport source (output valid, output sentence_byte, output last_byte, input ready);
    modport sink (input valid, input sentence_byte, input last_byte, output ready);
endinterface

interface nrcts_out_if;
    logic                         valid;
    logic                         ready;
    logic                         sentence_ok;
    logic [nrcts_pkg::BYTE_W-1:0] hour_tens;
    logic [nrcts_pkg::BYTE_W-1:0] hour_ones;
    logic [nrcts_pkg::BYTE_W-1:0] minute_tens;
    logic [nrcts_pkg::BYTE_W-1:0] minute_ones;
    logic [nrcts_pkg::BYTE_W-1:0] second_tens;
    logic [nrcts_pkg::BYTE_W-1:0] second_ones;

    modport source (
        output valid, output sentence_ok, output hour_tens, output hour_ones,
        output minute_tens, output minute_ones, output second_tens, output second_ones,
        input ready
    );
    modport sink (
        input valid, input sentence_ok, input hour_tens, input hour_ones,
        input minute_tens, input minute_ones, input second_tens, input second_ones,
        output ready
    );
endinterface

/* rtl/core/nrcts_parse.sv */
// Per-sentence parser state and end-of-sentence verdict for the RMC checker.
// Depends on nrcts_pkg for phase codes, character constants and helpers.
module nrcts_parse (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_step,
    input  logic [nrcts_pkg::BYTE_W-1:0] i_byte,
    input  logic                         i_last,
    output nrcts_pkg::t_result           o_result
);
    import nrcts_pkg::*;

    logic [POS_W-1:0]  r_pos,    n_pos;
    logic [BYTE_W-1:0] r_xor,    n_xor;
    t_phase            r_phase,  n_phase;
    logic              r_prefix, n_prefix;
    logic              r_comma,  n_comma;
    logic [CHK_W-1:0]  r_chk,    n_chk;
    t_clock_chars      r_cap,    n_cap;
    t_clock_chars      r_held,   n_held;

    logic [CHK_W-1:0]  hex_b;
    logic [2:0]        cap_idx;
    logic              ok;
    logic [3:0]        h_tens;
    logic [3:0]        h_ones;
    logic [6:0]        hour;
    logic [6:0]        hour_a;
    logic [6:0]        hour_b;
    logic [6:0]        hour_c;
    logic [3:0]        loc_tens;
    logic [6:0]        loc_ones;

    always_comb begin
        hex_b   = hex_value(i_byte);
        cap_idx = 3'(r_pos - POS_TIME_FIRST);

        n_prefix = r_prefix;
        if ((r_pos < POS_PREFIX_END) && (i_byte != prefix_char(r_pos[2:0]))) begin
            n_prefix = 1'b0;
        end
        n_comma = r_comma | ((r_pos == POS_COMMA) && (i_byte == CHAR_COMMA));

        n_cap = r_cap;
        if ((r_pos >= POS_TIME_FIRST) && (r_pos <= POS_TIME_LAST)) begin
            n_cap[cap_idx] = i_byte;
        end

        n_phase = r_phase;
        n_xor   = r_xor;
        n_chk   = r_chk;
        case (r_phase)
            PH_BEFORE_STAR: begin
                if (i_byte == CHAR_STAR) begin
                    n_phase = PH_FIRST_HEX;
                end else if (r_pos != '0) begin
                    n_xor = r_xor ^ i_byte;
                end
            end
            PH_FIRST_HEX: begin
                n_chk   = {hex_b[7:0], 4'b0};
                n_phase = PH_SECOND_HEX;
            end
            PH_SECOND_HEX: begin
                n_chk   = r_chk + hex_b;
                n_phase = PH_DONE;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase

        n_pos = (r_pos == POS_MAX) ? r_pos : r_pos + 4'd1;

        ok = n_prefix && (n_phase == PH_DONE) && (n_chk == {4'b0, n_xor}) && !n_comma
            && is_digit(n_cap[0]) && is_digit(n_cap[1]);

        // Hours in 0..99, shifted by the zone and reduced modulo 24 in three steps.
        h_tens = n_cap[0][3:0];
        h_ones = n_cap[1][3:0];
        hour   = {h_tens, 3'b0} + {2'b0, h_tens, 1'b0} + {3'b0, h_ones} + ZONE_HOURS;
        hour_a = (hour >= 7'd96) ? hour - 7'd96 : hour;
        hour_b = (hour_a >= 7'd48) ? hour_a - 7'd48 : hour_a;
        hour_c = (hour_b >= 7'd24) ? hour_b - 7'd24 : hour_b;
        loc_tens = (hour_c >= 7'd20) ? 4'd2 : ((hour_c >= 7'd10) ? 4'd1 : 4'd0);
        loc_ones = hour_c - ({loc_tens, 3'b0} + {2'b0, loc_tens, 1'b0});

        n_held = r_held;
        if (ok) begin
            n_held[0] = CHAR_ZERO | {4'b0, loc_tens};
            n_held[1] = CHAR_ZERO | {4'b0, loc_ones[3:0]};
            n_held[2] = n_cap[2];
            n_held[3] = n_cap[3];
            n_held[4] = n_cap[4];
            n_held[5] = n_cap[5];
        end

        o_result.ok          = ok;
        o_result.clock_chars = n_held;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= '0;
            r_xor    <= '0;
            r_phase  <= PH_BEFORE_STAR;
            r_prefix <= 1'b1;
            r_comma  <= 1'b0;
            r_chk    <= '0;
            r_cap    <= '0;
            r_held   <= '0;
        end else if (i_step) begin
            if (i_last) begin
                r_pos    <= '0;
                r_xor    <= '0;
                r_phase  <= PH_BEFORE_STAR;
                r_prefix <= 1'b1;
                r_comma  <= 1'b0;
                r_chk    <= '0;
                r_cap    <= '0;
                r_held   <= n_held;
            end else begin
                r_pos    <= n_pos;
                r_xor    <= n_xor;
                r_phase  <= n_phase;
                r_prefix <= n_prefix;
                r_comma  <= n_comma;
                r_chk    <= n_chk;
                r_cap    <= n_cap;
            end
        end
    end

endmodule

/* rtl/core/nmea_rmc_checksum_time_shift_top.sv */
// Top level of the RMC sentence checker with local time extraction.
// Depends on nrcts_pkg, the channel interfaces in nrcts_if and nrcts_parse.
//
// Usage:
// The input channel i_in carries one sentence byte per word, with last_byte
// set on the final byte of each sentence. The output channel o_out carries
// one word per sentence, sent after its last byte: sentence_ok says whether
// the "$GPRMC" prefix, the XOR checksum after '*' and the field checks passed,
// and the six time characters give the held local time (UTC plus eight hours).
// A passing sentence replaces the held time; a failing one leaves it as is.
//
// Throughput is one byte per cycle unless a stalled receiver holds back a last
// byte. Each accepted byte is registered, then the parser updates its
// per-sentence state from that register; on a last byte the verdict and time
// go into the output register. A result therefore passes the input register
// and then the output register on its way to o_out.
//
// When the receiver stalls, the pending result stays in the output register
// and bytes that produce no result keep flowing. A second last byte waits in
// the input register, and i_in.ready drops only then.
// Reset clears both valid flags, restarts the parser and zeroes the held time.
module nmea_rmc_checksum_time_shift_top (
    input  logic  i_clk,
    input  logic  i_rst_n,
    nrcts_in_if.sink    i_in,
    nrcts_out_if.source o_out
);
    import nrcts_pkg::*;

    // Input register stage.
    logic              r_s1_valid;
    logic [BYTE_W-1:0] r_s1_byte;
    logic              r_s1_last;

    // Output register stage.
    logic              r_out_valid;
    t_result           r_out;

    t_result           parse_result;
    logic              out_free;
    logic              s1_move;

    assign out_free   = !r_out_valid || o_out.ready;
    // A byte that ends no sentence never needs the output register.
    assign s1_move    = r_s1_valid && (!r_s1_last || out_free);
    assign i_in.ready = !r_s1_valid || s1_move;

    nrcts_parse u_parse (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (s1_move),
        .i_byte   (r_s1_byte),
        .i_last   (r_s1_last),
        .o_result (parse_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_s1_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.ready && i_in.valid) begin
            r_s1_byte <= i_in.sentence_byte;
            r_s1_last <= i_in.last_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move && r_s1_last) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1_last) begin
            r_out <= parse_result;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.sentence_ok = r_out.ok;
    assign o_out.hour_tens   = r_out.clock_chars[0];
    assign o_out.hour_ones   = r_out.clock_chars[1];
    assign o_out.minute_tens = r_out.clock_chars[2];
    assign o_out.minute_ones = r_out.clock_chars[3];
    assign o_out.second_tens = r_out.clock_chars[4];
    assign o_out.second_ones = r_out.clock_chars[5];

endmodule
